// File: rtl/core/rrt_pkg.sv
package rrt_pkg;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REPLY  = 2'd1,
        REQ_CANCEL = 2'd2,
        REQ_TICK   = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        K_ADDED    = 4'd0,
        K_FULL     = 4'd1,
        K_DUP      = 4'd2,
        K_MATCH    = 4'd3,
        K_UNMATCH  = 4'd4,
        K_CANCEL   = 4'd5,
        K_NOTFOUND = 4'd6,
        K_SENT     = 4'd7,
        K_DROP     = 4'd8,
        K_IDLE     = 4'd9
    } t_kind;

    localparam logic [1:0] CFG_SERVERS  = 2'd0;
    localparam logic [1:0] CFG_RETRY    = 2'd1;
    localparam logic [1:0] CFG_INTERVAL = 2'd2;

    localparam logic [3:0] RETRY_MAX = 4'd15;

    // one queued request between front and back
    typedef struct packed {
        t_req        req;
        logic [15:0] query_id;
        logic [15:0] owner_tag;
        logic [31:0] now;
    } t_cmd;

    // one result item
    typedef struct packed {
        t_kind       kind;
        logic [15:0] id;
        logic [1:0]  server;
        logic [3:0]  attempt;
        logic        last;
    } t_res;

endpackage

// File: rtl/core/request_retry_table_core.sv
// channel  | signals                                   | direction
// input    | push, full, i_req_type..i_now             | in
// result   | empty, pop, o_result_kind..o_last_result  | out
// config   | i_cfg_valid, o_cfg_ready, i_cfg_index/data| in
// a request waits in a two-entry queue; the engine takes it when idle, walks
// one table position per cycle and shows each result until it is taken. a tick
// drop is held back and shown once its last flag is known, and a send after
// drops repeats its table position.
// reset empties the table, sets server 0 and the register defaults.
// a held result stalls the engine; the queue takes two more items meanwhile.
module request_retry_table_core #(
    parameter int TABLE_SLOTS = 16,
    parameter int SERVER_MAX  = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_query_id,
    input  logic [15:0] i_owner_tag,
    input  logic [31:0] i_now,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_result_kind,
    output logic [15:0] o_result_id,
    output logic [1:0]  o_server_index,
    output logic [3:0]  o_attempt,
    output logic        o_last_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    logic [2:0] r_server_count;
    logic [3:0] r_retry_limit;
    logic [7:0] r_resend_interval;

    rrt_pkg::t_cmd w_in_cmd, w_q_cmd;
    rrt_pkg::t_res w_res;
    logic w_q_empty, w_take, w_res_valid, w_busy;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_count    <= 3'd1;
            r_retry_limit     <= 4'd5;
            r_resend_interval <= 8'd3;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == rrt_pkg::CFG_SERVERS)  r_server_count    <= i_cfg_data[2:0];
            if (i_cfg_index == rrt_pkg::CFG_RETRY)    r_retry_limit     <= i_cfg_data[3:0];
            if (i_cfg_index == rrt_pkg::CFG_INTERVAL) r_resend_interval <= i_cfg_data;
        end
    end

    assign w_in_cmd = '{req: rrt_pkg::t_req'(i_req_type), query_id: i_query_id,
                        owner_tag: i_owner_tag, now: i_now};

    // front queue
    rrt_cmd_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(w_in_cmd), .o_full(full),
        .i_pop(w_take), .o_empty(w_q_empty), .o_data(w_q_cmd)
    );

    // table engine
    rrt_engine #(.TABLE_SLOTS(TABLE_SLOTS), .SERVER_MAX(SERVER_MAX)) u_eng (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(!w_q_empty), .i_cmd(w_q_cmd), .o_cmd_take(w_take),
        .i_server_count(r_server_count), .i_retry_limit(r_retry_limit),
        .i_resend_interval(r_resend_interval),
        .o_res_valid(w_res_valid), .o_res(w_res), .i_res_take(pop),
        .o_busy(w_busy)
    );

    assign empty          = !w_res_valid;
    assign o_result_kind  = w_res.kind;
    assign o_result_id    = w_res.id;
    assign o_server_index = w_res.server;
    assign o_attempt      = w_res.attempt;
    assign o_last_result  = w_res.last;

    // an engine taking a request must have been idle
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> !w_busy) else $error("take while busy");
    // a result appears only while the engine is busy
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> w_busy) else $error("result while idle");
    // a sent result never precedes a further result of the same item
    a_sent_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res.kind == rrt_pkg::K_SENT) |-> w_res.last)
        else $error("sent not last");
endmodule

// File: rtl/core/rrt_cmd_fifo.sv
module rrt_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rrt_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output rrt_pkg::t_cmd o_data
);
    // two-entry queue between front and back
    rrt_pkg::t_cmd r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0)
                           - 2'((i_pop && !o_empty) ? 1 : 0);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
    end
endmodule

// File: rtl/core/rrt_engine.sv
module rrt_engine #(
    parameter int TABLE_SLOTS = 16,
    parameter int SERVER_MAX  = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  rrt_pkg::t_cmd i_cmd,
    output logic          o_cmd_take,
    input  logic [2:0]    i_server_count,
    input  logic [3:0]    i_retry_limit,
    input  logic [7:0]    i_resend_interval,
    output logic          o_res_valid,
    output rrt_pkg::t_res o_res,
    input  logic          i_res_take,
    output logic          o_busy
);
    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int SW = (SERVER_MAX > 1) ? $clog2(SERVER_MAX) : 1;
    localparam int KW = $clog2(SERVER_MAX + 1);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_OUT} t_state;

    // table kept as a shift list: position 0 is the newest entry
    logic [TABLE_SLOTS-1:0] r_valid;
    logic [15:0]            r_id      [TABLE_SLOTS];
    logic [15:0]            r_owner   [TABLE_SLOTS];
    logic                   r_sent    [TABLE_SLOTS];
    logic [3:0]             r_retries [TABLE_SLOTS];
    logic [31:0]            r_last    [TABLE_SLOTS];
    logic [SW-1:0]          r_next_srv;

    t_state        r_state;
    rrt_pkg::t_cmd r_cmd;
    logic [CW-1:0] r_pos;
    logic          r_more;
    logic          r_cont;
    logic          r_pend;
    logic [15:0]   r_pend_id;
    rrt_pkg::t_res r_res;

    t_state        n_state;
    rrt_pkg::t_cmd n_cmd;
    logic [CW-1:0] n_pos;
    logic          n_more;
    logic          n_cont;
    logic          n_pend;
    logic [15:0]   n_pend_id;
    rrt_pkg::t_res n_res;
    logic [SW-1:0] n_next_srv;

    // current walk entry
    logic [IW-1:0] w_ix;
    logic          w_in;
    logic          w_due;
    logic          w_drop;
    logic [KW-1:0] w_cnt;
    logic [SW-1:0] w_srv, w_srv_nx;
    logic [31:0]   w_el;
    logic [3:0]    w_att;
    logic          w_add;
    logic          w_send;
    logic          w_rm;

    assign w_ix  = r_pos[IW-1:0];
    assign w_in  = (r_pos < CW'(TABLE_SLOTS)) && r_valid[w_ix];
    assign w_el  = r_cmd.now - r_last[w_ix];
    assign w_due = !r_sent[w_ix] || (w_el > {24'd0, i_resend_interval});
    assign w_drop = r_retries[w_ix] > i_retry_limit;
    assign w_att = (r_retries[w_ix] == rrt_pkg::RETRY_MAX) ? r_retries[w_ix]
                                                          : r_retries[w_ix] + 4'd1;

    // round-robin server selection
    always_comb begin
        w_cnt = KW'(i_server_count);
        if (i_server_count == 3'd0) w_cnt = KW'(1);
        if (32'(i_server_count) > 32'(SERVER_MAX)) w_cnt = KW'(SERVER_MAX);
        w_srv = (KW'(r_next_srv) < w_cnt) ? r_next_srv : '0;
        w_srv_nx = (KW'(w_srv) + KW'(1) >= w_cnt) ? '0 : SW'(KW'(w_srv) + KW'(1));
    end

    assign o_cmd_take  = (r_state == S_IDLE) && i_cmd_valid;
    assign o_res_valid = (r_state == S_OUT);
    assign o_res       = r_res;
    assign o_busy      = (r_state != S_IDLE);

    // next-state logic: one table position per walk cycle
    // a tick drop is held back so its last flag is known when it is shown
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_pos      = r_pos;
        n_more     = r_more;
        n_cont     = r_cont;
        n_pend     = r_pend;
        n_pend_id  = r_pend_id;
        n_res      = r_res;
        n_next_srv = r_next_srv;
        w_add      = 1'b0;
        w_send     = 1'b0;
        w_rm       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd   = i_cmd;
                    n_pos   = '0;
                    n_pend  = 1'b0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                n_res   = '{kind: rrt_pkg::K_IDLE, id: 16'd0, server: 2'd0,
                            attempt: 4'd0, last: 1'b1};
                n_more  = 1'b0;
                n_cont  = 1'b0;
                n_state = S_OUT;
                if (!w_in) begin
                    // end of list
                    unique case (r_cmd.req)
                        rrt_pkg::REQ_ADD: begin
                            n_res.id = r_cmd.query_id;
                            if (r_valid[TABLE_SLOTS-1]) begin
                                n_res.kind = rrt_pkg::K_FULL;
                            end else begin
                                n_res.kind = rrt_pkg::K_ADDED;
                                w_add      = 1'b1;
                            end
                        end
                        rrt_pkg::REQ_REPLY: begin
                            n_res.kind = rrt_pkg::K_UNMATCH;
                            n_res.id   = r_cmd.query_id;
                        end
                        rrt_pkg::REQ_CANCEL: begin
                            n_res.kind = rrt_pkg::K_NOTFOUND;
                        end
                        default: begin
                            if (r_pend) begin
                                n_res.kind = rrt_pkg::K_DROP;
                                n_res.id   = r_pend_id;
                                n_pend     = 1'b0;
                            end
                        end
                    endcase
                end else begin
                    unique case (r_cmd.req)
                        rrt_pkg::REQ_ADD: begin
                            if (r_id[w_ix] == r_cmd.query_id) begin
                                n_res.kind = rrt_pkg::K_DUP;
                                n_res.id   = r_cmd.query_id;
                            end else begin
                                n_pos   = r_pos + CW'(1);
                                n_state = S_WALK;
                            end
                        end
                        rrt_pkg::REQ_REPLY, rrt_pkg::REQ_CANCEL: begin
                            if ((r_cmd.req == rrt_pkg::REQ_REPLY)
                                    ? (r_id[w_ix] == r_cmd.query_id)
                                    : (r_owner[w_ix] == r_cmd.owner_tag)) begin
                                n_res.kind = (r_cmd.req == rrt_pkg::REQ_REPLY)
                                             ? rrt_pkg::K_MATCH : rrt_pkg::K_CANCEL;
                                n_res.id   = r_id[w_ix];
                                n_more     = 1'b1;
                            end else begin
                                n_pos   = r_pos + CW'(1);
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            if (!w_due) begin
                                n_pos   = r_pos + CW'(1);
                                n_state = S_WALK;
                            end else if (w_drop && r_pend) begin
                                // show the held drop, hold this one, remove on take
                                n_res.kind = rrt_pkg::K_DROP;
                                n_res.id   = r_pend_id;
                                n_res.last = 1'b0;
                                n_pend_id  = r_id[w_ix];
                                n_more     = 1'b1;
                                n_cont     = 1'b1;
                            end else if (w_drop) begin
                                // hold this drop and remove the entry now
                                n_pend    = 1'b1;
                                n_pend_id = r_id[w_ix];
                                w_rm      = 1'b1;
                                n_state   = S_WALK;
                            end else if (r_pend) begin
                                // show the held drop, then revisit this entry
                                n_res.kind = rrt_pkg::K_DROP;
                                n_res.id   = r_pend_id;
                                n_res.last = 1'b0;
                                n_pend     = 1'b0;
                                n_cont     = 1'b1;
                            end else begin
                                n_res.kind    = rrt_pkg::K_SENT;
                                n_res.id      = r_id[w_ix];
                                n_res.server  = 2'(w_srv);
                                n_res.attempt = w_att;
                                n_next_srv    = w_srv_nx;
                                w_send        = 1'b1;
                            end
                        end
                    endcase
                end
            end
            default: begin
                // S_OUT: hold result, remove the flagged entry once taken
                if (i_res_take) begin
                    w_rm    = r_more;
                    n_state = r_cont ? S_WALK : S_IDLE;
                end
            end
        endcase
    end

    // sequencer state and table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_next_srv <= '0;
            r_pos      <= '0;
            r_more     <= 1'b0;
            r_cont     <= 1'b0;
            r_pend     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmd      <= n_cmd;
            r_pos      <= n_pos;
            r_more     <= n_more;
            r_cont     <= n_cont;
            r_pend     <= n_pend;
            r_pend_id  <= n_pend_id;
            r_res      <= n_res;
            r_next_srv <= n_next_srv;
            // new entry goes in as the newest
            if (w_add) begin
                r_valid <= {r_valid[TABLE_SLOTS-2:0], 1'b1};
                for (int k = TABLE_SLOTS - 1; k > 0; k--) begin
                    r_id[k]      <= r_id[k-1];
                    r_owner[k]   <= r_owner[k-1];
                    r_sent[k]    <= r_sent[k-1];
                    r_retries[k] <= r_retries[k-1];
                    r_last[k]    <= r_last[k-1];
                end
                r_id[0]      <= r_cmd.query_id;
                r_owner[0]   <= r_cmd.owner_tag;
                r_sent[0]    <= 1'b0;
                r_retries[0] <= '0;
                r_last[0]    <= '0;
            end
            // send updates the entry in place
            if (w_send) begin
                r_sent[w_ix]    <= 1'b1;
                r_retries[w_ix] <= w_att;
                r_last[w_ix]    <= r_cmd.now;
            end
            // removal closes the gap at the walk position
            if (w_rm) begin
                for (int k = 0; k < TABLE_SLOTS; k++) begin
                    if (CW'(k) >= r_pos) begin
                        if (k < TABLE_SLOTS - 1) begin
                            r_valid[k]   <= r_valid[k+1];
                            r_id[k]      <= r_id[k+1];
                            r_owner[k]   <= r_owner[k+1];
                            r_sent[k]    <= r_sent[k+1];
                            r_retries[k] <= r_retries[k+1];
                            r_last[k]    <= r_last[k+1];
                        end else begin
                            r_valid[k] <= 1'b0;
                        end
                    end
                end
            end
        end
    end
endmodule

// File: sim/tb_request_retry_table_core.sv
module tb_request_retry_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 16;
    localparam int SRV_MAX     = 4;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 60;

    // one outstanding transaction as the table holds it
    typedef struct {
        logic [15:0] id;
        logic [15:0] owner;
        logic        sent;
        logic [3:0]  retries;
        logic [31:0] last_try;
    } t_txn;

    // scoreboard: keeps a copy of the table, newest first, and the results it owes
    class retry_scoreboard;
        t_txn           pending_txns[$];
        rrt_pkg::t_res  owed_results[$];
        logic [2:0]     servers;
        logic [3:0]     retry_lim;
        logic [7:0]     interval;
        logic [1:0]     rr_server;
        int             errors;

        function void reset_state();
            pending_txns.delete();
            owed_results.delete();
            servers   = 3'd1;
            retry_lim = 4'd5;
            interval  = 8'd3;
            rr_server = 2'd0;
        endfunction

        function void note_config(logic [1:0] idx, logic [7:0] data);
            if (idx == rrt_pkg::CFG_SERVERS) servers = data[2:0];
            else if (idx == rrt_pkg::CFG_RETRY) retry_lim = data[3:0];
            else if (idx == rrt_pkg::CFG_INTERVAL) interval = data;
        endfunction

        function void owe(rrt_pkg::t_kind k, logic [15:0] id, logic [1:0] srv,
                          logic [3:0] att, logic last);
            rrt_pkg::t_res r;
            r.kind    = k;
            r.id      = id;
            r.server  = srv;
            r.attempt = att;
            r.last    = last;
            owed_results.push_back(r);
        endfunction

        // work out what one accepted request yields
        function void note_request(rrt_pkg::t_req req, logic [15:0] qid,
                                   logic [15:0] owner, logic [31:0] now);
            t_txn t;
            int   i;
            int   n_out;
            int   cnt;
            int   srv;
            case (req)
                rrt_pkg::REQ_ADD: begin
                    foreach (pending_txns[j])
                        if (pending_txns[j].id == qid) begin
                            owe(rrt_pkg::K_DUP, qid, 0, 0, 1);
                            return;
                        end
                    if (pending_txns.size() >= SLOTS) begin
                        owe(rrt_pkg::K_FULL, qid, 0, 0, 1);
                        return;
                    end
                    t.id = qid; t.owner = owner; t.sent = 0; t.retries = 0; t.last_try = 0;
                    pending_txns.push_front(t);
                    owe(rrt_pkg::K_ADDED, qid, 0, 0, 1);
                end
                rrt_pkg::REQ_REPLY, rrt_pkg::REQ_CANCEL: begin
                    foreach (pending_txns[j])
                        if ((req == rrt_pkg::REQ_REPLY) ? pending_txns[j].id == qid
                                                        : pending_txns[j].owner == owner) begin
                            owe(req == rrt_pkg::REQ_REPLY ? rrt_pkg::K_MATCH
                                                          : rrt_pkg::K_CANCEL,
                                pending_txns[j].id, 0, 0, 1);
                            pending_txns.delete(j);
                            return;
                        end
                    if (req == rrt_pkg::REQ_REPLY) owe(rrt_pkg::K_UNMATCH, qid, 0, 0, 1);
                    else owe(rrt_pkg::K_NOTFOUND, 16'd0, 0, 0, 1);
                end
                default: begin
                    // scan newest to oldest; drops first, then at most one send
                    i = 0;
                    n_out = 0;
                    while (i < pending_txns.size()) begin
                        t = pending_txns[i];
                        if (!t.sent || (now - t.last_try) > {24'd0, interval}) begin
                            if (t.retries > retry_lim) begin
                                owe(rrt_pkg::K_DROP, t.id, 0, 0, 0);
                                n_out++;
                                pending_txns.delete(i);
                                continue;
                            end
                            cnt = (servers == 0) ? 1 : (servers > SRV_MAX ? SRV_MAX : servers);
                            srv = (rr_server < cnt) ? rr_server : 0;
                            rr_server = 2'((srv + 1) % cnt);
                            t.sent = 1;
                            if (t.retries != rrt_pkg::RETRY_MAX) t.retries++;
                            t.last_try = now;
                            pending_txns[i] = t;
                            owe(rrt_pkg::K_SENT, t.id, 2'(srv), t.retries, 1);
                            return;
                        end
                        i++;
                    end
                    if (n_out == 0) owe(rrt_pkg::K_IDLE, 16'd0, 0, 0, 1);
                    else owed_results[owed_results.size() - 1].last = 1;
                end
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_result(logic [3:0] kind, logic [15:0] id, logic [1:0] srv,
                          logic [3:0] att, logic last);
            rrt_pkg::t_res e;
            if (owed_results.size() == 0) begin
                report($sformatf("unexpected result kind %0d id %h", kind, id));
                return;
            end
            e = owed_results.pop_front();
            if (kind !== e.kind) report($sformatf("kind %0d, want %0d", kind, e.kind));
            if (id !== e.id) report($sformatf("id %h, want %h", id, e.id));
            if (srv !== e.server) report($sformatf("server %0d, want %0d", srv, e.server));
            if (att !== e.attempt) report($sformatf("attempt %0d, want %0d", att, e.attempt));
            if (last !== e.last) report($sformatf("last %0d, want %0d", last, e.last));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_req_type;
    logic [15:0] i_query_id;
    logic [15:0] i_owner_tag;
    logic [31:0] i_now;
    logic        empty;
    logic        pop;
    logic [3:0]  o_result_kind;
    logic [15:0] o_result_id;
    logic [1:0]  o_server_index;
    logic [3:0]  o_attempt;
    logic        o_last_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    retry_scoreboard sb;
    logic [31:0]     clock_now;
    int              quiet_cycles;

    request_retry_table_core #(.TABLE_SLOTS(SLOTS), .SERVER_MAX(SRV_MAX)) dut (.*);

    // clock
    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else if (i_rst_n) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // send one item after a random gap
    task send_item(rrt_pkg::t_req req, logic [15:0] qid, logic [15:0] owner,
                   logic [31:0] now);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            push <= 0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1;
        i_req_type  <= req;
        i_query_id  <= qid;
        i_owner_tag <= owner;
        i_now       <= now;
        do @(posedge i_clk); while (full);
        sb.note_request(req, qid, owner, now);
    endtask

    task write_reg(logic [1:0] idx, logic [7:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        sb.note_config(idx, data);
    endtask

    // let every owed result drain and the engine settle
    task wait_idle();
        push <= 0;
        while (sb.owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function logic [15:0] pick_id();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14) return 16'($urandom_range(0, 19));
        if (sel < 18) return 16'($urandom);
        return sel[0] ? 16'hFFFF : 16'h0000;
    endfunction

    // random request mix; ticks carry a clock that mostly creeps forward
    task random_items(int count);
        int            sel;
        rrt_pkg::t_req req;
        repeat (count) begin
            sel = $urandom_range(0, 9);
            req = (sel < 4) ? rrt_pkg::REQ_ADD : (sel < 6) ? rrt_pkg::REQ_REPLY
                : (sel < 7) ? rrt_pkg::REQ_CANCEL : rrt_pkg::REQ_TICK;
            if (req == rrt_pkg::REQ_TICK) begin
                sel = $urandom_range(0, 19);
                if (sel == 0) clock_now = $urandom;
                else if (sel < 4) clock_now += sb.interval + $urandom_range(1, 3);
                else clock_now += $urandom_range(0, 4);
            end
            send_item(req, pick_id(),
                      ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7)),
                      (req == rrt_pkg::REQ_TICK) ? clock_now : 32'($urandom));
        end
    endtask

    // result side, with one long hold-off to back up the input
    initial begin
        int gap;
        int taken;
        taken = 0;
        pop <= 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 10);
            if (taken == 120) gap = 400;
            if (gap > 0) begin
                pop <= 0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1;
            do @(posedge i_clk); while (empty);
            sb.check_result(o_result_kind, o_result_id, o_server_index, o_attempt,
                            o_last_result);
            taken++;
        end
    end

    // stimulus
    initial begin
        logic [7:0] cfg_sets [6][3];
        sb = new();
        sb.errors = 0;
        sb.reset_state();
        quiet_cycles = 0;
        clock_now = 32'd100;
        i_rst_n     <= 0;
        push        <= 0;
        i_req_type  <= rrt_pkg::REQ_ADD;
        i_query_id  <= 0;
        i_owner_tag <= 0;
        i_now       <= 0;
        i_cfg_valid <= 0;
        i_cfg_index <= rrt_pkg::CFG_SERVERS;
        i_cfg_data  <= 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty table, fill, duplicate, full, wrapped times
        send_item(rrt_pkg::REQ_TICK, 16'h1234, 16'h0, 32'd5);
        send_item(rrt_pkg::REQ_CANCEL, 16'h0, 16'h0042, 32'd0);
        send_item(rrt_pkg::REQ_REPLY, 16'hFFFF, 16'h0, 32'd0);
        for (int k = 0; k < 15; k++) send_item(rrt_pkg::REQ_ADD, 16'(k), 16'(k % 3), 32'd0);
        send_item(rrt_pkg::REQ_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(rrt_pkg::REQ_ADD, 16'h0000, 16'h0001, 32'd0);
        send_item(rrt_pkg::REQ_ADD, 16'h0100, 16'h0001, 32'd0);
        send_item(rrt_pkg::REQ_TICK, 16'h0, 16'h0, 32'hFFFF_FFFF);
        send_item(rrt_pkg::REQ_REPLY, 16'hFFFF, 16'h0, 32'd0);
        send_item(rrt_pkg::REQ_CANCEL, 16'h0, 16'h0000, 32'd0);
        send_item(rrt_pkg::REQ_TICK, 16'h0, 16'h0, 32'd2);

        // reset defaults first, then register phases including the extremes
        random_items(80);
        cfg_sets = '{'{8'd1, 8'd0, 8'd0}, '{8'd4, 8'd14, 8'd255}, '{8'd0, 8'd15, 8'd0},
                     '{8'd7, 8'd1, 8'd2}, '{8'd3, 8'd0, 8'd1}, '{8'd2, 8'd2, 8'd5}};
        for (int p = 0; p < 6; p++) begin
            wait_idle();
            write_reg(rrt_pkg::CFG_SERVERS, cfg_sets[p][0]);
            write_reg(rrt_pkg::CFG_RETRY, cfg_sets[p][1]);
            write_reg(rrt_pkg::CFG_INTERVAL, cfg_sets[p][2]);
            if (p == 2) clock_now = 32'hFFFF_FFF0;
            random_items(68);
        end

        wait_idle();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
